// File: sv/rsus_pkg.sv
package rsus_pkg;

   localparam int DEF_MAX_CHILDREN = 256;
   localparam int RATING_W         = 16;
   localparam int COUNT_W          = 31;
   localparam int FRAC_BITS        = 16;
   localparam int URGENCY_BIAS     = 50;
   localparam int INDEX_OUT_W      = 8;
   localparam int REQ_DATA_W       = 48;

   typedef enum logic [3:0] {
      S_LOAD,
      S_OWN,
      S_CAPT,
      S_SCAN,
      S_TAIL,
      S_SHIFT,
      S_SUB,
      S_DIV,
      S_FIX,
      S_PICK,
      S_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store;
      logic first;
      logic capture;
      logic scan_issue;
      logic shift;
      logic sub;
      logic div_step;
      logic fix;
      logic pick;
      logic next_child;
      logic clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic child_last;
      logic div_done;
   } status_type;

endpackage

// File: sv/rsus_ram.sv
module rsus_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: sv/rsus_dpath.sv
module rsus_dpath #(
   parameter int MAX_CHILDREN = rsus_pkg::DEF_MAX_CHILDREN
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rsus_pkg::cmd_type                   cmd,
   output rsus_pkg::status_type                st,
   input  logic signed [rsus_pkg::RATING_W-1:0] in_rating,
   input  logic [rsus_pkg::COUNT_W-1:0]        in_count,
   output logic [rsus_pkg::INDEX_OUT_W-1:0]    chosen_index
);
   import rsus_pkg::*;

   localparam int CNT_W  = $clog2(MAX_CHILDREN + 1);
   localparam int IDX_W  = $clog2(MAX_CHILDREN);
   localparam int SUM_W  = COUNT_W + IDX_W;
   localparam int MAG_W  = SUM_W + FRAC_BITS;
   localparam int DEN_W  = COUNT_W + 1;
   localparam int STEP_W = $clog2(MAG_W + 1);
   localparam int URG_W  = MAG_W + 2;

   logic [CNT_W-1:0]          loaded_ff, loaded_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [CNT_W-1:0]          i_ff, j_ff;
   logic                      scan_valid_ff;
   logic signed [RATING_W-1:0] mine_ff;
   logic [COUNT_W-1:0]        own_cnt_ff;
   logic [CNT_W-1:0]          rank_ff;
   logic [MAG_W-1:0]          target_ff;
   logic [MAG_W-1:0]          quo_ff, quo_in;
   logic [DEN_W-1:0]          rem_ff, rem_in;
   logic [DEN_W-1:0]          den_ff;
   logic                      neg_ff;
   logic [STEP_W-1:0]         step_ff;
   logic signed [URG_W-1:0]   urg_ff, best_ff;
   logic [IDX_W-1:0]          chosen_ff;

   logic                      full, we;
   logic [IDX_W-1:0]          rd_addr;
   logic signed [RATING_W-1:0] rd_rating;
   logic [COUNT_W-1:0]        rd_count;
   logic [MAG_W:0]            num;
   logic [DEN_W:0]            rem_sh;
   logic                      ge;
   logic [URG_W-1:0]          q_adj;

   assign full    = (loaded_ff == CNT_W'(MAX_CHILDREN));
   assign we      = cmd.store && !full;
   assign rd_addr = cmd.scan_issue ? j_ff[IDX_W-1:0] : i_ff[IDX_W-1:0];

   rsus_ram #(.WIDTH(RATING_W), .DEPTH(MAX_CHILDREN)) u_rating_ram (
      .clock (clock),
      .we    (we),
      .waddr (loaded_ff[IDX_W-1:0]),
      .wdata (in_rating),
      .raddr (rd_addr),
      .rdata (rd_rating)
   );

   rsus_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_CHILDREN)) u_count_ram (
      .clock (clock),
      .we    (we),
      .waddr (loaded_ff[IDX_W-1:0]),
      .wdata (in_count),
      .raddr (i_ff[IDX_W-1:0]),
      .rdata (rd_count)
   );

   always_comb begin
      loaded_in = loaded_ff;
      sum_in    = sum_ff;
      if (cmd.clear) begin
         loaded_in = '0;
         sum_in    = '0;
      end else if (we) begin
         loaded_in = loaded_ff + CNT_W'(1);
         sum_in    = sum_ff + SUM_W'(in_count);
      end
   end

   // Signed numerator, two's complement, one bit wider than the magnitude.
   assign num = {1'b0, target_ff}
              - {1'b0, MAG_W'({own_cnt_ff, {FRAC_BITS{1'b0}}})};

   // Restoring division, one quotient bit a cycle.
   assign rem_sh = {rem_ff, quo_ff[MAG_W-1]};
   assign ge     = (rem_sh >= {1'b0, den_ff});
   assign rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
   assign quo_in = {quo_ff[MAG_W-2:0], ge};

   // Floor rounding: a negative quotient with a remainder rounds away from zero.
   assign q_adj = URG_W'(quo_ff) + URG_W'(neg_ff && (rem_ff != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff     <= '0;
         sum_ff        <= '0;
         scan_valid_ff <= 1'b0;
         step_ff       <= '0;
      end else begin
         loaded_ff     <= loaded_in;
         sum_ff        <= sum_in;
         scan_valid_ff <= cmd.scan_issue;
         if (cmd.sub) begin
            step_ff <= STEP_W'(MAG_W);
         end else if (cmd.div_step) begin
            step_ff <= step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.first) begin
         i_ff <= '0;
      end else if (cmd.next_child) begin
         i_ff <= i_ff + CNT_W'(1);
      end
      if (cmd.capture) begin
         mine_ff    <= rd_rating;
         own_cnt_ff <= rd_count;
         rank_ff    <= '0;
         j_ff       <= '0;
      end else begin
         if (cmd.scan_issue) begin
            j_ff <= j_ff + CNT_W'(1);
         end
         if (scan_valid_ff && (rd_rating > mine_ff)) begin
            rank_ff <= rank_ff + CNT_W'(1);
         end
      end
      if (cmd.shift) begin
         // A shift at or beyond the width yields zero.
         target_ff <= {sum_ff, {FRAC_BITS{1'b0}}} >> (rank_ff + CNT_W'(1));
      end
      if (cmd.sub) begin
         neg_ff <= num[MAG_W];
         quo_ff <= num[MAG_W] ? MAG_W'(-num) : num[MAG_W-1:0];
         rem_ff <= '0;
         den_ff <= DEN_W'(own_cnt_ff) + DEN_W'(URGENCY_BIAS);
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.fix) begin
         urg_ff <= neg_ff ? -$signed(q_adj) : $signed(q_adj);
      end
      if (cmd.pick && ((i_ff == '0) || (urg_ff > best_ff))) begin
         best_ff   <= urg_ff;
         chosen_ff <= i_ff[IDX_W-1:0];
      end
   end

   assign st.scan_last  = (j_ff + CNT_W'(1) == loaded_ff);
   assign st.child_last = (i_ff + CNT_W'(1) == loaded_ff);
   assign st.div_done   = (step_ff == '0);
   assign chosen_index  = INDEX_OUT_W'(chosen_ff);

   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CNT_W'(MAX_CHILDREN))
      else $error("child count beyond capacity");
   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> step_ff != '0)
      else $error("divider stepped past its last bit");
   a_pick_range: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> i_ff < loaded_ff)
      else $error("picked a child outside the list");

endmodule

// File: sv/rsus_ctrl.sv
module rsus_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsus_pkg::status_type st,
   output rsus_pkg::cmd_type    cmd
);
   import rsus_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:  if (req_valid && req_last) state_in = S_OWN;
         S_OWN:   state_in = S_CAPT;
         S_CAPT:  state_in = S_SCAN;
         S_SCAN:  if (st.scan_last) state_in = S_TAIL;
         S_TAIL:  state_in = S_SHIFT;
         S_SHIFT: state_in = S_SUB;
         S_SUB:   state_in = S_DIV;
         S_DIV:   if (st.div_done) state_in = S_FIX;
         S_FIX:   state_in = S_PICK;
         S_PICK:  state_in = st.child_last ? S_OUT : S_OWN;
         S_OUT:   if (rsp_ready) state_in = S_LOAD;
         default: state_in = S_LOAD;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            cmd.store = req_valid;
            cmd.first = req_valid && req_last;
         end
         S_OWN:   ;
         S_CAPT:  cmd.capture = 1'b1;
         S_SCAN:  cmd.scan_issue = 1'b1;
         S_TAIL:  ;
         S_SHIFT: cmd.shift = 1'b1;
         S_SUB:   cmd.sub = 1'b1;
         S_DIV:   cmd.div_step = !st.div_done;
         S_FIX:   cmd.fix = 1'b1;
         S_PICK: begin
            cmd.pick       = 1'b1;
            cmd.next_child = !st.child_last;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            cmd.clear = rsp_ready;
         end
         default: ;
      endcase
   end

endmodule

// File: sv/rank_share_urgency_select.sv
// Channel | Direction | Ports                           | Beat contents
// req     | in        | req_tvalid/tready/tdata/tlast   | one child; tlast ends the list
// rsp     | out       | rsp_tvalid/tready/tdata         | index of the most urgent child
//
// Children are stored at one beat per cycle. After the last beat, each of the n
// stored children is handled in turn: all n ratings are scanned through the
// rating memory's read port for its rank, then the shared divider runs (one
// quotient bit per cycle for 55 bits at the default size, then a check that it
// is done), with states for fetch, capture, shift, subtract, fix-up and compare.
// The result beat is offered once the last child has been compared.
// Reset is synchronous; no clearing pass is needed. Input is held off from the
// last beat until the result beat has been taken.
module rank_share_urgency_select #(
   parameter int MAX_CHILDREN = rsus_pkg::DEF_MAX_CHILDREN
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // child_rating [15:0], subtree_count [46:16], zero pad [47]
   input  logic [rsus_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // chosen_index [7:0]
   output logic [rsus_pkg::INDEX_OUT_W-1:0]    rsp_tdata
);
   import rsus_pkg::*;

   cmd_type    cmd;
   status_type st;

   // The controller sequences fetch, rank scan, divide and compare per child.
   rsus_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_last  (req_tlast),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .st        (st),
      .cmd       (cmd)
   );

   // The datapath holds the child memories, the running sum and the divider.
   rsus_dpath #(.MAX_CHILDREN(MAX_CHILDREN)) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .in_rating    ($signed(req_tdata[RATING_W-1:0])),
      .in_count     (req_tdata[RATING_W+COUNT_W-1:RATING_W]),
      .chosen_index (rsp_tdata)
   );

endmodule
